// ----- design/ogb_pkg.sv -----
// Shared types, codes and constants of the occupancy grid binning block.
package ogb_pkg;

    localparam int COORD_W        = 21;
    localparam int CS_W           = 16;
    localparam int THR_W          = 8;
    localparam int IDX_W          = 8;
    localparam int VAL_W          = 8;
    localparam int MAX_ADDR_W     = 24;
    localparam int APB_AW         = 5;
    localparam int APB_DW         = 32;

    localparam int GRID_COLS_DEF  = 256;
    localparam int GRID_ROWS_DEF  = 256;
    localparam int COUNT_BITS_DEF = 8;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_THRESH = 2'd1,
        OP_READ   = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_HEIGHT = 2'd1,
        ST_BOX    = 2'd2,
        ST_GRID   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        K_DONE   = 3'd0,
        K_ADD    = 3'd1,
        K_READ   = 3'd2,
        K_THRESH = 3'd3,
        K_CLEAR  = 3'd4
    } t_kind;

    typedef enum logic [2:0] {
        REG_BOX_MIN_X  = 3'd0,
        REG_BOX_MIN_Y  = 3'd1,
        REG_BOX_MAX_X  = 3'd2,
        REG_BOX_MAX_Y  = 3'd3,
        REG_CELL_SIZE  = 3'd4,
        REG_THRESHOLD  = 3'd5,
        REG_HEIGHT_MIN = 3'd6,
        REG_HEIGHT_MAX = 3'd7
    } t_reg;

    typedef struct packed {
        logic signed [COORD_W-1:0] box_min_x;
        logic signed [COORD_W-1:0] box_min_y;
        logic signed [COORD_W-1:0] box_max_x;
        logic signed [COORD_W-1:0] box_max_y;
        logic        [CS_W-1:0]    cell_size;
        logic        [THR_W-1:0]   hit_threshold;
        logic signed [COORD_W-1:0] height_min;
        logic signed [COORD_W-1:0] height_max;
    } t_cfg;

    typedef struct packed {
        t_kind                 kind;
        t_status               status;
        logic [IDX_W-1:0]      col;
        logic [IDX_W-1:0]      row;
        logic [MAX_ADDR_W-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// ----- design/ogb_if.sv -----
// Point and result channel interfaces of the occupancy grid binning block.
interface ogb_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           opcode;
    logic signed [ogb_pkg::COORD_W-1:0]   point_x;
    logic signed [ogb_pkg::COORD_W-1:0]   point_y;
    logic signed [ogb_pkg::COORD_W-1:0]   point_z;
    logic [ogb_pkg::IDX_W-1:0]            query_col;
    logic [ogb_pkg::IDX_W-1:0]            query_row;

    modport source (output valid, opcode, point_x, point_y, point_z, query_col, query_row,
                    input ready);
    modport sink   (input valid, opcode, point_x, point_y, point_z, query_col, query_row,
                    output ready);
endinterface

interface ogb_out_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [ogb_pkg::IDX_W-1:0] cell_col;
    logic [ogb_pkg::IDX_W-1:0] cell_row;
    logic [ogb_pkg::VAL_W-1:0] cell_value;

    modport source (output valid, status, cell_col, cell_row, cell_value, input ready);
    modport sink   (input valid, status, cell_col, cell_row, cell_value, output ready);
endinterface

// ----- design/ogb_div.sv -----
// Restoring divider, one quotient bit per cycle.
module ogb_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ogb_pkg::COORD_W-1:0]     i_dividend,
    input  logic [ogb_pkg::CS_W-1:0]        i_divisor,
    output logic                            o_done,
    output logic [ogb_pkg::COORD_W-1:0]     o_quot,
    output logic [ogb_pkg::CS_W-1:0]        o_rem
);
    localparam int CNT_W = $clog2(ogb_pkg::COORD_W);

    logic                          r_busy, r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [ogb_pkg::COORD_W-1:0]   r_quot;
    logic [ogb_pkg::CS_W-1:0]      r_rem, r_div;
    logic [ogb_pkg::CS_W:0]        n_shift;
    logic                          n_bit;

    always_comb begin
        n_shift = {r_rem, r_quot[ogb_pkg::COORD_W-1]};
        n_bit   = n_shift >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quot <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quot <= {r_quot[ogb_pkg::COORD_W-2:0], n_bit};
                r_rem  <= n_bit ? ogb_pkg::CS_W'(n_shift - {1'b0, r_div})
                                : n_shift[ogb_pkg::CS_W-1:0];
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(ogb_pkg::COORD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule

// ----- design/ogb_front.sv -----
// Front end: accepts items, checks the height band and box, finds the cell.
module ogb_front #(
    parameter int GRID_COLS = ogb_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = ogb_pkg::GRID_ROWS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ogb_pkg::t_cfg       i_cfg,
    input  logic                i_hold,
    ogb_in_if.sink              i_pts,
    input  ogb_pkg::t_fifo_stat i_fifo,
    output logic                o_push,
    output ogb_pkg::t_cmd       o_cmd
);
    localparam int COL_W = $clog2(GRID_COLS);
    localparam int ROW_W = $clog2(GRID_ROWS);
    localparam int AW    = ogb_pkg::MAX_ADDR_W;
    localparam int CW    = ogb_pkg::COORD_W;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate                r_state;
    ogb_pkg::t_cmd          r_cmd, n_acc_cmd, n_div_cmd;
    logic                   r_eqx, r_eqy;
    logic                   accept, start_div, height_bad, box_bad, beyond_x, beyond_y;
    logic signed [CW:0]     dx, dy, ex, ey;
    logic [ogb_pkg::CS_W-1:0] cs;
    logic                   done_x, done_y;
    logic [CW-1:0]          quot_x, quot_y;
    logic [ogb_pkg::CS_W-1:0] rem_x, rem_y;

    assign i_pts.ready = (r_state == F_IDLE) && !i_hold;
    assign accept      = i_pts.valid && i_pts.ready;
    assign cs          = (i_cfg.cell_size == '0) ? ogb_pkg::CS_W'(1) : i_cfg.cell_size;

    always_comb begin
        dx = {i_pts.point_x[CW-1], i_pts.point_x} - {i_cfg.box_min_x[CW-1], i_cfg.box_min_x};
        dy = {i_pts.point_y[CW-1], i_pts.point_y} - {i_cfg.box_min_y[CW-1], i_cfg.box_min_y};
        ex = {i_cfg.box_max_x[CW-1], i_cfg.box_max_x} - {i_cfg.box_min_x[CW-1], i_cfg.box_min_x};
        ey = {i_cfg.box_max_y[CW-1], i_cfg.box_max_y} - {i_cfg.box_min_y[CW-1], i_cfg.box_min_y};
        height_bad = (i_pts.point_z < i_cfg.height_min) || (i_pts.point_z > i_cfg.height_max);
        box_bad    = (i_pts.point_x < i_cfg.box_min_x) || (i_pts.point_x > i_cfg.box_max_x) ||
                     (i_pts.point_y < i_cfg.box_min_y) || (i_pts.point_y > i_cfg.box_max_y);
        start_div  = 1'b0;
        n_acc_cmd  = '{kind: ogb_pkg::K_DONE, status: ogb_pkg::ST_DONE,
                       col: '0, row: '0, addr: '0};
        unique case (ogb_pkg::t_op'(i_pts.opcode))
            ogb_pkg::OP_ADD: begin
                if (height_bad) begin
                    n_acc_cmd.status = ogb_pkg::ST_HEIGHT;
                end else if (box_bad) begin
                    n_acc_cmd.status = ogb_pkg::ST_BOX;
                end else begin
                    start_div = accept;
                end
            end
            ogb_pkg::OP_THRESH: n_acc_cmd.kind = ogb_pkg::K_THRESH;
            ogb_pkg::OP_READ: begin
                n_acc_cmd.col  = i_pts.query_col;
                n_acc_cmd.row  = i_pts.query_row;
                n_acc_cmd.addr = AW'(i_pts.query_col) * AW'(GRID_ROWS) + AW'(i_pts.query_row);
                if ((32'(i_pts.query_col) >= GRID_COLS) ||
                    (32'(i_pts.query_row) >= GRID_ROWS)) begin
                    n_acc_cmd.status = ogb_pkg::ST_GRID;
                end else begin
                    n_acc_cmd.kind = ogb_pkg::K_READ;
                end
            end
            ogb_pkg::OP_CLEAR: n_acc_cmd.kind = ogb_pkg::K_CLEAR;
            default: n_acc_cmd.kind = ogb_pkg::K_DONE;
        endcase
    end

    // A cell index can only reach the span when the point sits on the top edge
    // and the extent is a whole number of cells.
    always_comb begin
        beyond_x  = (r_eqx && rem_x == '0) || (quot_x >= CW'(GRID_COLS));
        beyond_y  = (r_eqy && rem_y == '0) || (quot_y >= CW'(GRID_ROWS));
        n_div_cmd = '{kind: ogb_pkg::K_ADD, status: ogb_pkg::ST_DONE,
                      col: quot_x[ogb_pkg::IDX_W-1:0], row: quot_y[ogb_pkg::IDX_W-1:0],
                      addr: AW'(quot_x[COL_W-1:0]) * AW'(GRID_ROWS) + AW'(quot_y[ROW_W-1:0])};
        if (beyond_x || beyond_y) begin
            n_div_cmd = '{kind: ogb_pkg::K_DONE, status: ogb_pkg::ST_GRID,
                          col: '0, row: '0, addr: '0};
        end
    end

    ogb_div u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start_div),
        .i_dividend(dx[CW-1:0]), .i_divisor(cs),
        .o_done(done_x), .o_quot(quot_x), .o_rem(rem_x)
    );

    ogb_div u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start_div),
        .i_dividend(dy[CW-1:0]), .i_divisor(cs),
        .o_done(done_y), .o_quot(quot_y), .o_rem(rem_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            unique case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_cmd   <= n_acc_cmd;
                        r_eqx   <= dx == ex;
                        r_eqy   <= dy == ey;
                        r_state <= start_div ? F_DIV : F_PUSH;
                    end
                end
                F_DIV: begin
                    if (done_x && done_y) begin
                        r_cmd   <= n_div_cmd;
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_fifo.full) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_push = (r_state == F_PUSH) && !i_fifo.full;
    assign o_cmd  = r_cmd;
endmodule

// ----- design/ogb_fifo.sv -----
// Two-entry command queue between the front end and the grid engine.
module ogb_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ogb_pkg::t_cmd       i_cmd,
    input  logic                i_pop,
    output ogb_pkg::t_cmd       o_cmd,
    output ogb_pkg::t_fifo_stat o_stat
);
    ogb_pkg::t_cmd r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_cmd;
                r_wp        <= ~r_wp;
            end
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_cmd        = r_mem[r_rp];
    assign o_stat.full  = r_cnt == 2'd2;
    assign o_stat.empty = r_cnt == 2'd0;
endmodule

// ----- design/ogb_back.sv -----
// Grid engine: counter memory, update, read, threshold and clear sweeps.
module ogb_back #(
    parameter int GRID_COLS  = ogb_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS  = ogb_pkg::GRID_ROWS_DEF,
    parameter int COUNT_BITS = ogb_pkg::COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [ogb_pkg::THR_W-1:0] i_threshold,
    input  ogb_pkg::t_cmd       i_cmd,
    input  ogb_pkg::t_fifo_stat i_fifo,
    output logic                o_pop,
    output logic                o_init_busy,
    ogb_out_if.source           o_res
);
    localparam int CELLS = GRID_COLS * GRID_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = (COUNT_BITS > ogb_pkg::VAL_W) ? COUNT_BITS : ogb_pkg::VAL_W;

    typedef enum logic [4:0] {
        B_IDLE   = 5'b00001,
        B_EXEC   = 5'b00010,
        B_CLR    = 5'b00100,
        B_THR_RD = 5'b01000,
        B_THR_WR = 5'b10000
    } t_bstate;

    logic [COUNT_BITS-1:0] r_mem [CELLS];
    logic [COUNT_BITS-1:0] r_rdata, n_count, wdata;
    t_bstate               r_state;
    ogb_pkg::t_cmd         r_cmd;
    logic [AW-1:0]         r_idx, addr;
    logic                  r_init, we, re, last, slot_free, out_load;
    logic                  r_ovalid;
    ogb_pkg::t_status      r_ostatus;
    logic [ogb_pkg::IDX_W-1:0] r_ocol, r_orow;
    logic [ogb_pkg::VAL_W-1:0] r_oval;
    logic [RW-1:0]         ext_new, ext_rd;

    assign slot_free = !r_ovalid || o_res.ready;
    assign o_pop     = (r_state == B_IDLE) && !i_fifo.empty && slot_free;
    assign last      = r_idx == AW'(CELLS - 1);
    assign n_count   = (r_rdata == {COUNT_BITS{1'b1}}) ? r_rdata : r_rdata + 1'b1;
    assign ext_new   = RW'(n_count);
    assign ext_rd    = RW'(r_rdata);

    // A result is loaded for a status-only command, after a cell access, and at
    // the end of a sweep that a command started.
    assign out_load = (r_state == B_EXEC) ||
                      ((r_state == B_IDLE) && o_pop &&
                       !(i_cmd.kind inside {ogb_pkg::K_ADD, ogb_pkg::K_READ,
                                            ogb_pkg::K_CLEAR, ogb_pkg::K_THRESH})) ||
                      ((r_state == B_CLR || r_state == B_THR_WR) && last && !r_init);

    always_comb begin
        we    = 1'b0;
        re    = 1'b0;
        addr  = r_idx;
        wdata = '0;
        unique case (r_state)
            B_IDLE: begin
                addr = i_cmd.addr[AW-1:0];
                re   = o_pop && (i_cmd.kind == ogb_pkg::K_ADD || i_cmd.kind == ogb_pkg::K_READ);
            end
            B_EXEC: begin
                addr  = r_cmd.addr[AW-1:0];
                we    = r_cmd.kind == ogb_pkg::K_ADD;
                wdata = n_count;
            end
            B_CLR: we = 1'b1;
            B_THR_RD: re = 1'b1;
            B_THR_WR: begin
                we    = 1'b1;
                wdata = (ext_rd > RW'(i_threshold)) ? COUNT_BITS'(1) : '0;
            end
            default: we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[addr] <= wdata;
        if (re) r_rdata <= r_mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_CLR;
            r_init   <= 1'b1;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state) inside
                B_IDLE: begin
                    if (o_pop) begin
                        r_cmd <= i_cmd;
                        r_idx <= '0;
                        case (i_cmd.kind) inside
                            ogb_pkg::K_ADD, ogb_pkg::K_READ: r_state <= B_EXEC;
                            ogb_pkg::K_CLEAR:                r_state <= B_CLR;
                            ogb_pkg::K_THRESH:               r_state <= B_THR_RD;
                            default: begin
                                r_ostatus <= i_cmd.status;
                                r_ocol    <= i_cmd.col;
                                r_orow    <= i_cmd.row;
                                r_oval    <= '0;
                            end
                        endcase
                    end
                end
                B_EXEC: begin
                    r_ostatus <= ogb_pkg::ST_DONE;
                    r_ocol    <= r_cmd.col;
                    r_orow    <= r_cmd.row;
                    if (r_cmd.kind == ogb_pkg::K_ADD) begin
                        r_oval <= (ext_new > RW'(255)) ? 8'hFF : ext_new[ogb_pkg::VAL_W-1:0];
                    end else begin
                        r_oval <= (ext_rd > RW'(255)) ? 8'hFF : ext_rd[ogb_pkg::VAL_W-1:0];
                    end
                    r_state <= B_IDLE;
                end
                B_CLR, B_THR_WR: begin
                    r_idx <= r_idx + 1'b1;
                    if (last) begin
                        r_state <= B_IDLE;
                        r_init  <= 1'b0;
                        if (!r_init) begin
                            r_ostatus <= ogb_pkg::ST_DONE;
                            r_ocol    <= '0;
                            r_orow    <= '0;
                            r_oval    <= '0;
                        end
                    end else begin
                        r_state <= (r_state == B_CLR) ? B_CLR : B_THR_RD;
                    end
                end
                B_THR_RD: r_state <= B_THR_WR;
                default: r_state <= B_IDLE;
            endcase
        end
    end

    assign o_init_busy      = r_init;
    assign o_res.valid      = r_ovalid;
    assign o_res.status     = r_ostatus;
    assign o_res.cell_col   = r_ocol;
    assign o_res.cell_row   = r_orow;
    assign o_res.cell_value = r_oval;
endmodule

// ----- design/occupancy_grid_binning.sv -----
// Top level of the occupancy grid binning block: registers, front end, queue, engine.
//
//  Channel  Direction  Carries                                      Transfer when
//  i_pts    in         opcode, point_x/y/z, query_col/row           valid && ready
//  o_res    out        status, cell_col, cell_row, cell_value       valid && ready
//  APB      in/out     box, cell size, threshold, height band       psel&penable&pwrite
//
// An added point goes through the two bit-serial dividers (21 steps) that divide the
// x and y offsets by the cell size. Threshold reads and then writes each cell, and
// clear writes each cell, over the whole grid through the single memory port.
// After reset the engine clears the whole grid, during which no item is taken;
// register writes are taken at any time. The queue and the output register let the
// front end keep accepting, until the queue is full, while a result waits to be taken.
module occupancy_grid_binning #(
    parameter int GRID_COLS  = ogb_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS  = ogb_pkg::GRID_ROWS_DEF,
    parameter int COUNT_BITS = ogb_pkg::COUNT_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ogb_in_if.sink                        i_pts,
    ogb_out_if.source                     o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ogb_pkg::APB_AW-1:0]    paddr,
    input  logic [ogb_pkg::APB_DW-1:0]    pwdata,
    output logic [ogb_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    ogb_pkg::t_cfg       r_cfg;
    ogb_pkg::t_cmd       front_cmd, head_cmd;
    ogb_pkg::t_fifo_stat fifo_stat;
    logic                push, pop, init_busy, cfg_we;
    ogb_pkg::t_reg       reg_sel;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign reg_sel = ogb_pkg::t_reg'(paddr[ogb_pkg::APB_AW-1:2]);

    // Register file; the coordinate registers keep the low 21 bits of the write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.box_min_x     <= '0;
            r_cfg.box_min_y     <= '0;
            r_cfg.box_max_x     <= ogb_pkg::COORD_W'(25600);
            r_cfg.box_max_y     <= ogb_pkg::COORD_W'(25600);
            r_cfg.cell_size     <= ogb_pkg::CS_W'(100);
            r_cfg.hit_threshold <= ogb_pkg::THR_W'(2);
            r_cfg.height_min    <= ogb_pkg::COORD_W'(-1000);
            r_cfg.height_max    <= ogb_pkg::COORD_W'(1000);
        end else if (cfg_we) begin
            unique case (reg_sel)
                ogb_pkg::REG_BOX_MIN_X:  r_cfg.box_min_x     <= pwdata[ogb_pkg::COORD_W-1:0];
                ogb_pkg::REG_BOX_MIN_Y:  r_cfg.box_min_y     <= pwdata[ogb_pkg::COORD_W-1:0];
                ogb_pkg::REG_BOX_MAX_X:  r_cfg.box_max_x     <= pwdata[ogb_pkg::COORD_W-1:0];
                ogb_pkg::REG_BOX_MAX_Y:  r_cfg.box_max_y     <= pwdata[ogb_pkg::COORD_W-1:0];
                ogb_pkg::REG_CELL_SIZE:  r_cfg.cell_size     <= pwdata[ogb_pkg::CS_W-1:0];
                ogb_pkg::REG_THRESHOLD:  r_cfg.hit_threshold <= pwdata[ogb_pkg::THR_W-1:0];
                ogb_pkg::REG_HEIGHT_MIN: r_cfg.height_min    <= pwdata[ogb_pkg::COORD_W-1:0];
                ogb_pkg::REG_HEIGHT_MAX: r_cfg.height_max    <= pwdata[ogb_pkg::COORD_W-1:0];
                default: r_cfg.cell_size <= r_cfg.cell_size;
            endcase
        end
    end

    // Reads return signed registers sign-extended to the bus width.
    always_comb begin
        unique case (reg_sel)
            ogb_pkg::REG_BOX_MIN_X:  prdata = ogb_pkg::APB_DW'(r_cfg.box_min_x);
            ogb_pkg::REG_BOX_MIN_Y:  prdata = ogb_pkg::APB_DW'(r_cfg.box_min_y);
            ogb_pkg::REG_BOX_MAX_X:  prdata = ogb_pkg::APB_DW'(r_cfg.box_max_x);
            ogb_pkg::REG_BOX_MAX_Y:  prdata = ogb_pkg::APB_DW'(r_cfg.box_max_y);
            ogb_pkg::REG_CELL_SIZE:  prdata = ogb_pkg::APB_DW'(r_cfg.cell_size);
            ogb_pkg::REG_THRESHOLD:  prdata = ogb_pkg::APB_DW'(r_cfg.hit_threshold);
            ogb_pkg::REG_HEIGHT_MIN: prdata = ogb_pkg::APB_DW'(r_cfg.height_min);
            ogb_pkg::REG_HEIGHT_MAX: prdata = ogb_pkg::APB_DW'(r_cfg.height_max);
            default: prdata = '0;
        endcase
    end

    ogb_front #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_hold(init_busy),
        .i_pts(i_pts), .i_fifo(fifo_stat), .o_push(push), .o_cmd(front_cmd)
    );

    ogb_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_cmd(front_cmd),
        .i_pop(pop), .o_cmd(head_cmd), .o_stat(fifo_stat)
    );

    ogb_back #(.GRID_COLS(GRID_COLS), .GRID_ROWS(GRID_ROWS), .COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_threshold(r_cfg.hit_threshold),
        .i_cmd(head_cmd), .i_fifo(fifo_stat), .o_pop(pop), .o_init_busy(init_busy),
        .o_res(o_res)
    );
endmodule

// ----- design/ogb_checker.sv -----
// Port-level assertions of the occupancy grid binning block and their bind.
module ogb_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_ready,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic [1:0]                i_status,
    input logic [ogb_pkg::IDX_W-1:0] i_col,
    input logic [ogb_pkg::IDX_W-1:0] i_row,
    input logic [ogb_pkg::VAL_W-1:0] i_value
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ogb_pkg::ST_HEIGHT || i_status == ogb_pkg::ST_BOX)
        |-> i_col == '0 && i_row == '0 && i_value == '0)
        else $error("dropped point reports a cell");

    a_grid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ogb_pkg::ST_GRID |-> i_value == '0)
        else $error("out-of-grid result has a value");

    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result after reset");

    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !i_in_ready)
        else $error("item taken during clearing pass");
endmodule

bind occupancy_grid_binning ogb_checker u_ogb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_ready(i_pts.ready),
    .i_out_valid(o_res.valid), .i_out_ready(o_res.ready), .i_status(o_res.status),
    .i_col(o_res.cell_col), .i_row(o_res.cell_row), .i_value(o_res.cell_value)
);

// ----- test/occupancy_grid_binning_tb.sv -----
// Self-checking testbench of the occupancy grid binning block.
module occupancy_grid_binning_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOLS = ogb_pkg::GRID_COLS_DEF;
    localparam int NROWS = ogb_pkg::GRID_ROWS_DEF;
    localparam longint CYCLE_LIMIT = 64'd30000000;

    typedef struct packed {
        ogb_pkg::t_op                       op;
        logic [ogb_pkg::COORD_W-1:0]        x;
        logic [ogb_pkg::COORD_W-1:0]        y;
        logic [ogb_pkg::COORD_W-1:0]        z;
        logic [ogb_pkg::IDX_W-1:0]          qcol;
        logic [ogb_pkg::IDX_W-1:0]          qrow;
    } t_item;

    typedef struct packed {
        ogb_pkg::t_status               status;
        logic [ogb_pkg::IDX_W-1:0]      col;
        logic [ogb_pkg::IDX_W-1:0]      row;
        logic [ogb_pkg::VAL_W-1:0]      value;
    } t_result;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [ogb_pkg::APB_AW-1:0] paddr;
    logic [ogb_pkg::APB_DW-1:0] pwdata;
    logic [ogb_pkg::APB_DW-1:0] prdata;
    logic pready;

    ogb_in_if  pts_ch ();
    ogb_out_if res_ch ();

    occupancy_grid_binning dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pts   (pts_ch.sink),
        .o_res   (res_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the grid and of the register file that the predictor uses.
    logic [7:0]        grid_counts [NCOLS*NROWS];
    ogb_pkg::t_cfg     shadow_cfg;

    t_item   pending_points [$];
    t_result expected_results [$];

    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_off_cycles;
    int  failures;
    longint cycle_count;

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // A timeout ends the run as failed; this should never happen on a correct block.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Counts down a requested receiver hold-off, one cycle per clock.
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0)
            hold_off_cycles <= hold_off_cycles - 1;
    end

    // Number of cells that an extent lo..hi spans, rounded up; zero for an empty box.
    function automatic longint span_cells(input logic signed [ogb_pkg::COORD_W-1:0] lo,
                                          input logic signed [ogb_pkg::COORD_W-1:0] hi,
                                          input longint cs);
        longint ext;
        ext = longint'(hi) - longint'(lo);
        if (ext <= 0)
            return 0;
        return (ext + cs - 1) / cs;
    endfunction

    // Predicts the result of one transferred item and updates the shadow grid.
    function automatic t_result bin_point(input t_item it);
        t_result r;
        logic signed [ogb_pkg::COORD_W-1:0] px, py, pz;
        longint cs, col, row;
        int idx;
        r = '0;
        r.status = ogb_pkg::ST_DONE;
        px = it.x;
        py = it.y;
        pz = it.z;
        case (it.op)
            ogb_pkg::OP_ADD: begin
                cs = (shadow_cfg.cell_size == 0) ? 1 : longint'(shadow_cfg.cell_size);
                if (pz < shadow_cfg.height_min || pz > shadow_cfg.height_max) begin
                    r.status = ogb_pkg::ST_HEIGHT;
                end else if (px < shadow_cfg.box_min_x || px > shadow_cfg.box_max_x ||
                             py < shadow_cfg.box_min_y || py > shadow_cfg.box_max_y) begin
                    r.status = ogb_pkg::ST_BOX;
                end else begin
                    // Offsets are non-negative here, so truncation equals floor.
                    col = (longint'(px) - longint'(shadow_cfg.box_min_x)) / cs;
                    row = (longint'(py) - longint'(shadow_cfg.box_min_y)) / cs;
                    if (col >= span_cells(shadow_cfg.box_min_x, shadow_cfg.box_max_x, cs) ||
                        col >= NCOLS ||
                        row >= span_cells(shadow_cfg.box_min_y, shadow_cfg.box_max_y, cs) ||
                        row >= NROWS) begin
                        r.status = ogb_pkg::ST_GRID;
                    end else begin
                        idx = int'(col) * NROWS + int'(row);
                        if (grid_counts[idx] != 8'hFF)
                            grid_counts[idx] = grid_counts[idx] + 8'd1;
                        r.col   = col[7:0];
                        r.row   = row[7:0];
                        r.value = grid_counts[idx];
                    end
                end
            end
            ogb_pkg::OP_THRESH: begin
                for (int i = 0; i < NCOLS*NROWS; i++)
                    grid_counts[i] = (grid_counts[i] > shadow_cfg.hit_threshold) ? 8'd1 : 8'd0;
            end
            ogb_pkg::OP_READ: begin
                r.col   = it.qcol;
                r.row   = it.qrow;
                if (int'(it.qcol) >= NCOLS || int'(it.qrow) >= NROWS)
                    r.status = ogb_pkg::ST_GRID;
                else
                    r.value = grid_counts[int'(it.qcol) * NROWS + int'(it.qrow)];
            end
            default: begin
                for (int i = 0; i < NCOLS*NROWS; i++)
                    grid_counts[i] = '0;
            end
        endcase
        return r;
    endfunction

    // Driver: offers the oldest pending item, with random idle cycles between
    // transfers. The predictor runs on each transfer so expectations stay in order.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pts_ch.valid <= 1'b0;
        end else begin
            if (pts_ch.valid && pts_ch.ready) begin
                expected_results.push_back(bin_point(pending_points.pop_front()));
            end
            if (!pts_ch.valid || pts_ch.ready) begin
                if (pending_points.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct) begin
                    pts_ch.valid     <= 1'b1;
                    pts_ch.opcode    <= pending_points[0].op;
                    pts_ch.point_x   <= pending_points[0].x;
                    pts_ch.point_y   <= pending_points[0].y;
                    pts_ch.point_z   <= pending_points[0].z;
                    pts_ch.query_col <= pending_points[0].qcol;
                    pts_ch.query_row <= pending_points[0].qrow;
                end else begin
                    pts_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer against the oldest expectation and
    // drives the ready line, held low while a hold-off is running.
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got.status = ogb_pkg::t_status'(res_ch.status);
                got.col    = res_ch.cell_col;
                got.row    = res_ch.cell_row;
                got.value  = res_ch.cell_value;
                if (expected_results.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected result, expected none, actual %p", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.col !== want.col ||
                        got.row !== want.row || got.value !== want.value) begin
                        failures++;
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $time, want, got);
                    end
                end
            end
            if (hold_off_cycles > 0)
                res_ch.ready <= 1'b0;
            else
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // One register write through the configuration port, mirrored in the shadow copy.
    task automatic write_reg(input ogb_pkg::t_reg which, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ogb_pkg::APB_AW'(int'(which) * 4);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (which)
            ogb_pkg::REG_BOX_MIN_X:  shadow_cfg.box_min_x     = value[ogb_pkg::COORD_W-1:0];
            ogb_pkg::REG_BOX_MIN_Y:  shadow_cfg.box_min_y     = value[ogb_pkg::COORD_W-1:0];
            ogb_pkg::REG_BOX_MAX_X:  shadow_cfg.box_max_x     = value[ogb_pkg::COORD_W-1:0];
            ogb_pkg::REG_BOX_MAX_Y:  shadow_cfg.box_max_y     = value[ogb_pkg::COORD_W-1:0];
            ogb_pkg::REG_CELL_SIZE:  shadow_cfg.cell_size     = value[ogb_pkg::CS_W-1:0];
            ogb_pkg::REG_THRESHOLD:  shadow_cfg.hit_threshold = value[ogb_pkg::THR_W-1:0];
            ogb_pkg::REG_HEIGHT_MIN: shadow_cfg.height_min    = value[ogb_pkg::COORD_W-1:0];
            default:                 shadow_cfg.height_max    = value[ogb_pkg::COORD_W-1:0];
        endcase
    endtask

    task automatic write_box(input int min_x, input int min_y, input int max_x,
                             input int max_y, input int cs);
        write_reg(ogb_pkg::REG_BOX_MIN_X, min_x);
        write_reg(ogb_pkg::REG_BOX_MIN_Y, min_y);
        write_reg(ogb_pkg::REG_BOX_MAX_X, max_x);
        write_reg(ogb_pkg::REG_BOX_MAX_Y, max_y);
        write_reg(ogb_pkg::REG_CELL_SIZE, cs);
    endtask

    // Waits until every queued item has transferred and every result has come back,
    // then lets the engine settle before a register write.
    task automatic drain;
        while (pending_points.size() != 0 || pts_ch.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic t_item make_point(input int x, input int y, input int z);
        t_item it;
        it = '0;
        it.op = ogb_pkg::OP_ADD;
        it.x = ogb_pkg::COORD_W'(x);
        it.y = ogb_pkg::COORD_W'(y);
        it.z = ogb_pkg::COORD_W'(z);
        return it;
    endfunction

    function automatic t_item make_op(input ogb_pkg::t_op op, input int qc, input int qr);
        t_item it;
        it = '0;
        it.op = op;
        it.qcol = ogb_pkg::IDX_W'(qc);
        it.qrow = ogb_pkg::IDX_W'(qr);
        it.x = ogb_pkg::COORD_W'($urandom);
        it.y = ogb_pkg::COORD_W'($urandom);
        it.z = ogb_pkg::COORD_W'($urandom);
        return it;
    endfunction

    // Mostly points near the box with a random height, sometimes raw noise;
    // reads usually aim at cells that hits could have reached.
    function automatic t_item random_item(input int span);
        t_item it;
        int pick;
        pick = $urandom_range(99);
        if (pick < 72) begin
            it = make_point(int'(shadow_cfg.box_min_x) + $urandom_range(span) - 20,
                            int'(shadow_cfg.box_min_y) + $urandom_range(span) - 20,
                            int'(shadow_cfg.height_min) + $urandom_range(2200) - 100);
            if ($urandom_range(9) == 0) begin
                it.x = ogb_pkg::COORD_W'($urandom);
                it.y = ogb_pkg::COORD_W'($urandom);
                it.z = ogb_pkg::COORD_W'($urandom);
            end
        end else if (pick < 94) begin
            it = make_op(ogb_pkg::OP_READ, $urandom_range(9), $urandom_range(9));
            if ($urandom_range(3) == 0) begin
                it.qcol = ogb_pkg::IDX_W'($urandom);
                it.qrow = ogb_pkg::IDX_W'($urandom);
            end
        end else if (pick < 97) begin
            it = make_op(ogb_pkg::OP_THRESH, $urandom, $urandom);
        end else begin
            it = make_op(ogb_pkg::OP_CLEAR, $urandom, $urandom);
        end
        return it;
    endfunction

    initial begin
        shadow_cfg.box_min_x     = 0;
        shadow_cfg.box_min_y     = 0;
        shadow_cfg.box_max_x     = 25600;
        shadow_cfg.box_max_y     = 25600;
        shadow_cfg.cell_size     = 100;
        shadow_cfg.hit_threshold = 2;
        shadow_cfg.height_min    = -1000;
        shadow_cfg.height_max    = 1000;
        for (int i = 0; i < NCOLS*NROWS; i++)
            grid_counts[i] = '0;
        failures        = 0;
        cycle_count     = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        pts_ch.valid     = 1'b0;
        pts_ch.opcode    = '0;
        pts_ch.point_x   = '0;
        pts_ch.point_y   = '0;
        pts_ch.point_z   = '0;
        pts_ch.query_col = '0;
        pts_ch.query_row = '0;
        res_ch.ready     = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset registers: corners, edges, every drop reason,
        // reads inside and at the grid's far corner, threshold and clear.
        pending_points.push_back(make_point(0, 0, 0));
        pending_points.push_back(make_point(0, 0, -1000));
        pending_points.push_back(make_point(25599, 25599, 1000));
        pending_points.push_back(make_point(25600, 25600, 0));
        pending_points.push_back(make_point(0, 0, -1001));
        pending_points.push_back(make_point(0, 0, 1001));
        pending_points.push_back(make_point(-1, 50, 0));
        pending_points.push_back(make_point(25601, 50, 0));
        pending_points.push_back(make_point(-1048576, 1048575, 0));
        pending_points.push_back(make_point(5, 5, -1048576));
        pending_points.push_back(make_point(5, 5, 1048575));
        pending_points.push_back(make_point(1048575, -1048576, 0));
        pending_points.push_back(make_op(ogb_pkg::OP_READ, 0, 0));
        pending_points.push_back(make_op(ogb_pkg::OP_READ, 255, 255));
        pending_points.push_back(make_op(ogb_pkg::OP_READ, 0, 255));
        pending_points.push_back(make_op(ogb_pkg::OP_THRESH, 0, 0));
        pending_points.push_back(make_op(ogb_pkg::OP_READ, 0, 0));
        pending_points.push_back(make_op(ogb_pkg::OP_CLEAR, 0, 0));
        pending_points.push_back(make_op(ogb_pkg::OP_READ, 0, 0));
        drain();

        // A small box whose extent is not a multiple of the cell, so the last
        // partial cell still counts; then saturate one counter past 255.
        write_box(-300, -300, 250, 250, 100);
        write_reg(ogb_pkg::REG_THRESHOLD, 0);
        write_reg(ogb_pkg::REG_HEIGHT_MIN, -5);
        write_reg(ogb_pkg::REG_HEIGHT_MAX, 5);
        for (int i = 0; i < 260; i++)
            pending_points.push_back(make_point(-300, -300, 0));
        pending_points.push_back(make_point(250, 250, 5));
        pending_points.push_back(make_op(ogb_pkg::OP_THRESH, 0, 0));
        pending_points.push_back(make_op(ogb_pkg::OP_READ, 0, 0));
        drain();

        // Long receiver hold-off while the sender keeps offering, so the
        // block fills up and stalls its input.
        hold_off_cycles = 3000;
        for (int i = 0; i < 40; i++)
            pending_points.push_back(random_item(600));
        drain();

        // Random phases, each with its own register setting and one of four idling mixes.
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            case (phase)
                0: write_box(0, 0, 900, 900, 100);
                1: write_box(-1048576, -1048576, -1047576, -1047576, 0);
                2: write_box(1047575, 1047575, 1048575, 1048575, 1);
                3: write_box(-500, -500, 500, 500, 65535);
                4: write_box(800, 800, 100, 100, 50);
                5: write_box(-4000, 2000, 2000, 2700, 7);
                6: write_box(0, 0, 25600, 25600, 100);
                default: write_box(-1000, -1000, 1000, 1000, 333);
            endcase
            write_reg(ogb_pkg::REG_THRESHOLD, (phase == 3) ? 255 : $urandom_range(4));
            write_reg(ogb_pkg::REG_HEIGHT_MIN, (phase == 1) ? -1048576 : -1000);
            write_reg(ogb_pkg::REG_HEIGHT_MAX, (phase == 1) ? 1048575 : 1000);
            pending_points.push_back(make_op(ogb_pkg::OP_CLEAR, 0, 0));
            for (int i = 0; i < 72; i++)
                pending_points.push_back(random_item((phase == 2) ? 1100 : 1500));
            drain();
        end

        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
